>>> src/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

    localparam int unsigned DADDR_W = 30;

    typedef enum logic [1:0] {
        OP_PRELOAD = 2'd0,
        OP_STEP    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    localparam logic [5:0] OPC_RTYPE = 6'd0;
    localparam logic [5:0] OPC_ALT   = 6'd10;
    localparam logic [5:0] OPC_SLTU  = 6'd11;
    localparam logic [5:0] OPC_ADDI  = 6'd8;
    localparam logic [5:0] OPC_LW    = 6'd35;
    localparam logic [5:0] OPC_SW    = 6'd43;
    localparam logic [5:0] OPC_LUI   = 6'd15;
    localparam logic [5:0] OPC_BEQ   = 6'd4;
    localparam logic [5:0] OPC_J     = 6'd2;

    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SLT   = 6'd42;
    localparam logic [5:0] FN_SLTU  = 6'd43;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_SHL16 = 6'd4;
    localparam logic [5:0] FN_NOTA  = 6'd39;

    typedef enum logic [2:0] {
        ALU_ADD   = 3'd0,
        ALU_SUB   = 3'd1,
        ALU_SLT   = 3'd2,
        ALU_SLTU  = 3'd3,
        ALU_AND   = 3'd4,
        ALU_OR    = 3'd5,
        ALU_SHL16 = 3'd6,
        ALU_NOTA  = 3'd7
    } alu_sel_t;

    typedef struct packed {
        logic     valid;
        alu_sel_t sel;
        logic     use_imm;
        logic     wr;
        logic     to_rd;
        logic     ld;
        logic     st;
        logic     br;
        logic     jmp;
    } ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_READ_A,
        ST_READ_B,
        ST_EXEC,
        ST_WRAP,
        ST_MEM_RD,
        ST_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] load_index;
        logic [31:0] load_data;
    } req_t;

    typedef struct packed {
        logic        halted;
        logic [31:0] pc_after;
        logic [31:0] fetched_instruction;
        logic [31:0] alu_result;
        logic        zero_flag;
        logic        reg_write_done;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        mem_write_done;
    } rsp_t;

endpackage

>>> src/msc_stream_if.sv
`timescale 1ns / 1ps

interface msc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/msc_ram.sv
`timescale 1ns / 1ps

module msc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/msc_wrap.sv
`timescale 1ns / 1ps

module msc_wrap #(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [msc_pkg::DADDR_W-1:0]      value,
    output logic                             done,
    output logic [$clog2(MEM_WORDS)-1:0]     idx
);

    localparam int unsigned AW   = $clog2(MEM_WORDS);
    localparam int unsigned VW   = msc_pkg::DADDR_W;
    localparam bit          POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    generate
        if (POW2)
        begin : g_mask
            logic          done_reg;
            logic [AW-1:0] idx_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= value[AW-1:0];
                end
            end

            assign done = done_reg;
            assign idx  = idx_reg;
        end
        else
        begin : g_recip
            localparam int unsigned     SH    = VW + AW;
            localparam int unsigned     PW    = VW + 32;
            localparam longint unsigned RECIP =
                ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);

            logic          mul_vld_reg;
            logic          sub_vld_reg;
            logic          done_reg;
            logic [VW-1:0] val_reg;
            logic [PW-1:0] prod_reg;
            logic [VW-1:0] qm_reg;
            logic [AW-1:0] idx_reg;
            logic [VW-1:0] quot;
            logic [VW-1:0] rem;

            // quotient by reciprocal multiply, then remainder by one subtract
            assign quot = VW'(prod_reg >> SH);
            assign rem  = val_reg - qm_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mul_vld_reg <= 1'b0;
                    sub_vld_reg <= 1'b0;
                    done_reg    <= 1'b0;
                end
                else
                begin
                    mul_vld_reg <= start;
                    sub_vld_reg <= mul_vld_reg;
                    done_reg    <= sub_vld_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    val_reg  <= value;
                    prod_reg <= PW'(value) * PW'(RECIP);
                end
                if (mul_vld_reg)
                begin
                    qm_reg <= quot * VW'(MEM_WORDS);
                end
                if (sub_vld_reg)
                begin
                    idx_reg <= rem[AW-1:0];
                end
            end

            assign done = done_reg;
            assign idx  = idx_reg;
        end
    endgenerate

endmodule

>>> src/msc_decode.sv
`timescale 1ns / 1ps

module msc_decode (
    input  logic [31:0]     ins,
    output msc_pkg::ctrl_t  ctrl
);

    logic [5:0] opcode;
    logic [5:0] funct;

    assign opcode = ins[31:26];
    assign funct  = ins[5:0];

    always_comb
    begin
        ctrl = '0;
        unique case (opcode)
            msc_pkg::OPC_RTYPE, msc_pkg::OPC_ALT:
            begin
                ctrl.valid = 1'b1;
                ctrl.wr    = 1'b1;
                ctrl.to_rd = 1'b1;
                unique case (funct)
                    msc_pkg::FN_ADD:   ctrl.sel = msc_pkg::ALU_ADD;
                    msc_pkg::FN_SUB:   ctrl.sel = msc_pkg::ALU_SUB;
                    msc_pkg::FN_SLT:   ctrl.sel = msc_pkg::ALU_SLT;
                    msc_pkg::FN_SLTU:  ctrl.sel = msc_pkg::ALU_SLTU;
                    msc_pkg::FN_AND:   ctrl.sel = msc_pkg::ALU_AND;
                    msc_pkg::FN_OR:    ctrl.sel = msc_pkg::ALU_OR;
                    msc_pkg::FN_SHL16: ctrl.sel = msc_pkg::ALU_SHL16;
                    msc_pkg::FN_NOTA:  ctrl.sel = msc_pkg::ALU_NOTA;
                    default:           ctrl = '0;
                endcase
            end
            msc_pkg::OPC_SLTU:
            begin
                ctrl.valid = 1'b1;
                ctrl.sel   = msc_pkg::ALU_SLTU;
                ctrl.wr    = 1'b1;
                ctrl.to_rd = 1'b1;
            end
            msc_pkg::OPC_ADDI:
            begin
                ctrl.valid   = 1'b1;
                ctrl.sel     = msc_pkg::ALU_ADD;
                ctrl.use_imm = 1'b1;
                ctrl.wr      = 1'b1;
            end
            msc_pkg::OPC_LW:
            begin
                ctrl.valid   = 1'b1;
                ctrl.sel     = msc_pkg::ALU_ADD;
                ctrl.use_imm = 1'b1;
                ctrl.wr      = 1'b1;
                ctrl.ld      = 1'b1;
            end
            msc_pkg::OPC_SW:
            begin
                ctrl.valid   = 1'b1;
                ctrl.sel     = msc_pkg::ALU_ADD;
                ctrl.use_imm = 1'b1;
                ctrl.st      = 1'b1;
            end
            msc_pkg::OPC_LUI:
            begin
                ctrl.valid   = 1'b1;
                ctrl.sel     = msc_pkg::ALU_SHL16;
                ctrl.use_imm = 1'b1;
                ctrl.wr      = 1'b1;
            end
            msc_pkg::OPC_BEQ:
            begin
                ctrl.valid = 1'b1;
                ctrl.sel   = msc_pkg::ALU_SUB;
                ctrl.br    = 1'b1;
            end
            msc_pkg::OPC_J:
            begin
                ctrl.valid = 1'b1;
                ctrl.sel   = msc_pkg::ALU_ADD;
                ctrl.jmp   = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

>>> src/msc_alu.sv
`timescale 1ns / 1ps

module msc_alu (
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    input  msc_pkg::alu_sel_t sel,
    output logic [31:0]       y
);

    always_comb
    begin
        unique case (sel)
            msc_pkg::ALU_ADD:   y = a + b;
            msc_pkg::ALU_SUB:   y = a - b;
            msc_pkg::ALU_SLT:   y = {31'd0, $signed(a) < $signed(b)};
            msc_pkg::ALU_SLTU:  y = {31'd0, a < b};
            msc_pkg::ALU_AND:   y = a & b;
            msc_pkg::ALU_OR:    y = a | b;
            msc_pkg::ALU_SHL16: y = {b[15:0], 16'd0};
            msc_pkg::ALU_NOTA:  y = ~a;
            default:            y = '0;
        endcase
    end

endmodule

>>> src/mips_subset_single_cycle_core.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                  | Handshake
// --------+-----+------------------------------------------+-------------------
// req     | in  | operation, load_index, load_data         | valid / ready
// rsp     | out | halted, pc_after, fetched_instruction,   | valid / ready
//         |     | alu_result, zero_flag, reg_write_*,      |
//         |     | mem_write_done                           |
// cfg     | in  | start_pc                                 | cfg_we, no wait
//
// One request at a time. Restart, ignored codes and halted or bad-pc steps go straight
// to the result; preload reduces its index, then writes the word RAM. A step fetches,
// reads rs then rt, executes (an unknown opcode or funct halts here), reduces the data
// address and writes or reads the word RAM for stores and loads, then writes back.
// Reduction is a mask when MEM_WORDS is a power of two, else a reciprocal-multiply
// remainder unit. The register RAM has one read port; the word RAM read is registered.
// The result register frees the request side while rsp stalls. Reset clears pc, halt,
// start_pc and the register valid bits; word memory is unset until preloaded.

module mips_subset_single_cycle_core #(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    msc_stream_if.sink          req,
    msc_stream_if.source        rsp
);

    localparam int unsigned AW = $clog2(MEM_WORDS);

    msc_pkg::state_t state_reg, state_next;

    logic [31:0]      pc_reg, pc_next;
    logic             halt_reg, halt_next;
    logic [31:0]      start_pc_reg, start_pc_next;
    logic [31:0]      rf_valid_reg, rf_valid_next;
    logic             preload_reg, preload_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [31:0]      ins_reg, ins_next;
    logic [31:0]      a_reg, a_next;
    logic [31:0]      b_reg, b_next;
    logic [31:0]      res_reg, res_next;
    logic [31:0]      wval_reg, wval_next;
    logic [31:0]      ld_data_reg, ld_data_next;
    msc_pkg::rsp_t    pend_reg, pend_next;
    msc_pkg::rsp_t    rsp_data_reg, rsp_data_next;
    msc_pkg::rsp_t    fin;

    logic             req_fire;
    msc_pkg::op_t     req_op;
    logic             pc_bad;
    logic             out_free;

    msc_pkg::ctrl_t   ctrl;
    logic [31:0]      ext;
    logic [31:0]      alu_b;
    logic [31:0]      alu_y;
    logic [4:0]       dst;
    logic [31:0]      npc_seq;
    logic [31:0]      br_target;
    logic [31:0]      jmp_target;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [31:0]      mem_rdata;

    logic             rf_we;
    logic [4:0]       rf_waddr;
    logic [31:0]      rf_wdata;
    logic [4:0]       rf_raddr;
    logic [31:0]      rf_rdata;

    logic                         wrap_start;
    logic [msc_pkg::DADDR_W-1:0]  wrap_value;
    logic                         wrap_done;
    logic [AW-1:0]                wrap_idx;

    assign req_fire  = req.valid && req.ready;
    assign req_op    = msc_pkg::op_t'(req.data.operation);
    assign pc_bad    = (pc_reg[1:0] != 2'd0) ||
                       (pc_reg[31:2] >= msc_pkg::DADDR_W'(MEM_WORDS));
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign ext        = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign alu_b      = ctrl.use_imm ? ext : b_reg;
    assign dst        = ctrl.to_rd ? ins_reg[15:11] : ins_reg[20:16];
    assign npc_seq    = pc_reg + 32'd4;
    assign br_target  = npc_seq + {ext[29:0], 2'b00};
    assign jmp_target = {npc_seq[31:28], ins_reg[25:0], 2'b00};

    msc_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    msc_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_reg_ram (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    msc_wrap #(
        .MEM_WORDS (MEM_WORDS)
    ) u_wrap (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wrap_start),
        .value (wrap_value),
        .done  (wrap_done),
        .idx   (wrap_idx)
    );

    msc_decode u_decode (
        .ins  (ins_reg),
        .ctrl (ctrl)
    );

    msc_alu u_alu (
        .a   (a_reg),
        .b   (alu_b),
        .sel (ctrl.sel),
        .y   (alu_y)
    );

    always_comb
    begin
        fin          = pend_reg;
        fin.halted   = halt_reg;
        fin.pc_after = pc_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_op)
                        msc_pkg::OP_PRELOAD: state_next = msc_pkg::ST_WRAP;
                        msc_pkg::OP_STEP:
                        begin
                            if (halt_reg || pc_bad)
                            begin
                                state_next = msc_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = msc_pkg::ST_FETCH;
                            end
                        end
                        msc_pkg::OP_RESTART: state_next = msc_pkg::ST_DONE;
                        default:             state_next = msc_pkg::ST_DONE;
                    endcase
                end
            end
            msc_pkg::ST_FETCH:  state_next = msc_pkg::ST_READ_A;
            msc_pkg::ST_READ_A: state_next = msc_pkg::ST_READ_B;
            msc_pkg::ST_READ_B: state_next = msc_pkg::ST_EXEC;
            msc_pkg::ST_EXEC:
            begin
                priority if (!ctrl.valid)
                begin
                    state_next = msc_pkg::ST_DONE;
                end
                else if (ctrl.ld || ctrl.st)
                begin
                    state_next = msc_pkg::ST_WRAP;
                end
                else
                begin
                    state_next = msc_pkg::ST_WB;
                end
            end
            msc_pkg::ST_WRAP:
            begin
                if (wrap_done)
                begin
                    priority if (preload_reg)
                    begin
                        state_next = msc_pkg::ST_DONE;
                    end
                    else if (ctrl.ld)
                    begin
                        state_next = msc_pkg::ST_MEM_RD;
                    end
                    else
                    begin
                        state_next = msc_pkg::ST_WB;
                    end
                end
            end
            msc_pkg::ST_MEM_RD: state_next = msc_pkg::ST_WB;
            msc_pkg::ST_WB:     state_next = msc_pkg::ST_DONE;
            msc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = msc_pkg::ST_IDLE;
                end
            end
            default:            state_next = msc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready      = (state_reg == msc_pkg::ST_IDLE);
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        start_pc_next  = cfg_we ? cfg_wdata : start_pc_reg;
        rf_valid_next  = rf_valid_reg;
        preload_next   = preload_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        ins_next       = ins_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        wval_next      = wval_reg;
        ld_data_next   = ld_data_reg;
        pend_next      = pend_reg;

        mem_we     = 1'b0;
        mem_waddr  = wrap_idx;
        mem_wdata  = b_reg;
        mem_raddr  = pc_reg[AW+1:2];
        rf_we      = 1'b0;
        rf_waddr   = dst;
        rf_wdata   = wval_reg;
        rf_raddr   = ins_reg[25:21];
        wrap_start = 1'b0;
        wrap_value = res_reg[31:2];

        unique case (state_reg)
            msc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    pend_next    = '0;
                    preload_next = (req_op == msc_pkg::OP_PRELOAD);
                    ld_data_next = req.data.load_data;
                    unique case (req_op)
                        msc_pkg::OP_PRELOAD:
                        begin
                            wrap_start = 1'b1;
                            wrap_value = msc_pkg::DADDR_W'(req.data.load_index);
                        end
                        msc_pkg::OP_STEP:
                        begin
                            if (!halt_reg && pc_bad)
                            begin
                                halt_next = 1'b1;
                            end
                        end
                        msc_pkg::OP_RESTART:
                        begin
                            pc_next   = start_pc_reg;
                            halt_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            msc_pkg::ST_FETCH:
            begin
                ins_next                      = mem_rdata;
                pend_next.fetched_instruction = mem_rdata;
                rf_raddr                      = mem_rdata[25:21];
            end
            msc_pkg::ST_READ_A:
            begin
                a_next   = rf_valid_reg[ins_reg[25:21]] ? rf_rdata : 32'd0;
                rf_raddr = ins_reg[20:16];
            end
            msc_pkg::ST_READ_B:
            begin
                b_next = rf_valid_reg[ins_reg[20:16]] ? rf_rdata : 32'd0;
            end
            msc_pkg::ST_EXEC:
            begin
                if (!ctrl.valid)
                begin
                    halt_next = 1'b1;
                end
                else
                begin
                    res_next             = alu_y;
                    wval_next            = alu_y;
                    pend_next.alu_result = alu_y;
                    pend_next.zero_flag  = (alu_y == 32'd0);
                    wrap_start           = ctrl.ld || ctrl.st;
                    wrap_value           = alu_y[31:2];
                end
            end
            msc_pkg::ST_WRAP:
            begin
                mem_raddr = wrap_idx;
                if (wrap_done)
                begin
                    if (preload_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = ld_data_reg;
                    end
                    else if (ctrl.st)
                    begin
                        mem_we                   = 1'b1;
                        pend_next.mem_write_done = 1'b1;
                    end
                end
            end
            msc_pkg::ST_MEM_RD:
            begin
                wval_next = mem_rdata;
            end
            msc_pkg::ST_WB:
            begin
                if (ctrl.wr)
                begin
                    rf_we                     = 1'b1;
                    rf_valid_next[dst]        = 1'b1;
                    pend_next.reg_write_done  = 1'b1;
                    pend_next.reg_write_index = dst;
                    pend_next.reg_write_value = wval_reg;
                end
                priority if (ctrl.jmp)
                begin
                    pc_next = jmp_target;
                end
                else if (ctrl.br && (res_reg == 32'd0))
                begin
                    pc_next = br_target;
                end
                else
                begin
                    pc_next = npc_seq;
                end
            end
            msc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = fin;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msc_pkg::ST_IDLE;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            start_pc_reg  <= '0;
            rf_valid_reg  <= '0;
            preload_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            start_pc_reg  <= start_pc_next;
            rf_valid_reg  <= rf_valid_next;
            preload_reg   <= preload_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg      <= ins_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        wval_reg     <= wval_next;
        ld_data_reg  <= ld_data_next;
        pend_reg     <= pend_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

>>> src/msc_checker.sv
`timescale 1ns / 1ps

module msc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input msc_pkg::rsp_t rsp_data
);

    logic [1:0] cnt_reg, cnt_next;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("request accepted while another is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cnt_reg != 2'd0)
        else $error("result without an outstanding request");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("more than two requests outstanding");

endmodule

bind mips_subset_single_cycle_core msc_checker u_msc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

>>> sim/mips_subset_single_cycle_core_test.sv
`timescale 1ns / 1ps

module mips_subset_single_cycle_core_test;
    import msc_pkg::*;

    localparam int unsigned MEM_WORDS = 65536;
    localparam int PLAN_VIEW = 0;
    localparam int ACCEPT_VIEW = 1;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [5:0] FN_UNUSED = 6'd1;
    localparam logic [5:0] FUNCT_CODES [8] = '{FN_ADD, FN_SUB, FN_SLT, FN_SLTU,
                                                FN_AND, FN_OR, FN_SHL16, FN_NOTA};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    msc_stream_if #(.payload_t(req_t)) request_bus ();
    msc_stream_if #(.payload_t(rsp_t)) result_bus ();

    mips_subset_single_cycle_core #(.MEM_WORDS(MEM_WORDS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(request_bus),
        .rsp(result_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bit [31:0] core_pc [2];
    bit        core_halt [2];
    bit [31:0] core_regs [2][32];
    bit [31:0] core_mem [2][MEM_WORDS];
    bit        word_written [MEM_WORDS];
    bit [31:0] start_addr;

    req_t request_queue [$];
    rsp_t item_outcomes [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int planned_items;
    int accepted = 0;
    int steps_accepted = 0;
    int results_checked = 0;
    int halted_results = 0;
    int settings_used = 0;
    int errors = 0;
    rsp_t want;
    rsp_t got;

    function automatic rsp_t execute_request(int view, req_t r);
        rsp_t        o;
        logic [31:0] ins, a, b, ext, opnd, res, wval, npc;
        logic [4:0]  dst;
        alu_sel_t    sel;
        logic        known, use_imm, wr, to_rd, ld, st, br, jmp;
        int unsigned widx;
        o = '0;
        case (r.operation)
            OP_PRELOAD:
            begin
                core_mem[view][r.load_index % MEM_WORDS] = r.load_data;
                word_written[r.load_index % MEM_WORDS] = 1'b1;
            end
            OP_STEP:
            begin
                if (core_halt[view])
                    o = '0;
                else if (core_pc[view][1:0] != 2'b00 || (core_pc[view] >> 2) >= MEM_WORDS)
                    core_halt[view] = 1'b1;
                else
                begin
                    ins = core_mem[view][core_pc[view] >> 2];
                    o.fetched_instruction = ins;
                    a = core_regs[view][ins[25:21]];
                    b = core_regs[view][ins[20:16]];
                    ext = {{16{ins[15]}}, ins[15:0]};
                    sel = ALU_ADD;
                    known = 1'b1;
                    use_imm = 1'b0;
                    wr = 1'b0;
                    to_rd = 1'b0;
                    ld = 1'b0;
                    st = 1'b0;
                    br = 1'b0;
                    jmp = 1'b0;
                    case (ins[31:26])
                        OPC_RTYPE, OPC_ALT:
                        begin
                            wr = 1'b1;
                            to_rd = 1'b1;
                            case (ins[5:0])
                                FN_ADD:   sel = ALU_ADD;
                                FN_SUB:   sel = ALU_SUB;
                                FN_SLT:   sel = ALU_SLT;
                                FN_SLTU:  sel = ALU_SLTU;
                                FN_AND:   sel = ALU_AND;
                                FN_OR:    sel = ALU_OR;
                                FN_SHL16: sel = ALU_SHL16;
                                FN_NOTA:  sel = ALU_NOTA;
                                default:  known = 1'b0;
                            endcase
                        end
                        OPC_SLTU:
                        begin
                            sel = ALU_SLTU;
                            wr = 1'b1;
                            to_rd = 1'b1;
                        end
                        OPC_ADDI:
                        begin
                            use_imm = 1'b1;
                            wr = 1'b1;
                        end
                        OPC_LW:
                        begin
                            use_imm = 1'b1;
                            wr = 1'b1;
                            ld = 1'b1;
                        end
                        OPC_SW:
                        begin
                            use_imm = 1'b1;
                            st = 1'b1;
                        end
                        OPC_LUI:
                        begin
                            sel = ALU_SHL16;
                            use_imm = 1'b1;
                            wr = 1'b1;
                        end
                        OPC_BEQ:
                        begin
                            sel = ALU_SUB;
                            br = 1'b1;
                        end
                        OPC_J:
                            jmp = 1'b1;
                        default:
                            known = 1'b0;
                    endcase
                    if (!known)
                        core_halt[view] = 1'b1;
                    else
                    begin
                        opnd = use_imm ? ext : b;
                        case (sel)
                            ALU_ADD:   res = a + opnd;
                            ALU_SUB:   res = a - opnd;
                            ALU_SLT:   res = {31'd0, $signed(a) < $signed(opnd)};
                            ALU_SLTU:  res = {31'd0, a < opnd};
                            ALU_AND:   res = a & opnd;
                            ALU_OR:    res = a | opnd;
                            ALU_SHL16: res = opnd << 16;
                            default:   res = ~a;
                        endcase
                        o.alu_result = res;
                        o.zero_flag = (res == 32'd0);
                        widx = (res >> 2) % MEM_WORDS;
                        wval = ld ? core_mem[view][widx] : res;
                        if (st)
                        begin
                            core_mem[view][widx] = b;
                            word_written[widx] = 1'b1;
                            o.mem_write_done = 1'b1;
                        end
                        if (wr)
                        begin
                            dst = to_rd ? ins[15:11] : ins[20:16];
                            core_regs[view][dst] = wval;
                            o.reg_write_done = 1'b1;
                            o.reg_write_index = dst;
                            o.reg_write_value = wval;
                        end
                        npc = core_pc[view] + 32'd4;
                        if (br && res == 32'd0)
                            npc = npc + (ext << 2);
                        if (jmp)
                            npc = {npc[31:28], ins[25:0], 2'b00};
                        core_pc[view] = npc;
                    end
                end
            end
            OP_RESTART:
            begin
                core_pc[view] = start_addr;
                core_halt[view] = 1'b0;
            end
            default:
                o = '0;
        endcase
        o.halted = core_halt[view];
        o.pc_after = core_pc[view];
        return o;
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [5:0]  code;
        int          off;
        w = $urandom();
        off = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 15))
            0, 1, 2:
            begin
                w[31:26] = $urandom_range(0, 1) ? OPC_RTYPE : OPC_ALT;
                w[5:0] = FUNCT_CODES[$urandom_range(0, 7)];
            end
            3:
                w[31:26] = OPC_SLTU;
            4, 5:
                w[31:26] = OPC_ADDI;
            6:
                w[31:26] = OPC_LUI;
            7:
                w[31:26] = OPC_LW;
            8:
                w[31:26] = OPC_SW;
            9, 10:
            begin
                w[31:26] = OPC_BEQ;
                if ($urandom_range(0, 3) != 0)
                    w[15:0] = off[15:0];
            end
            11:
            begin
                w[31:26] = OPC_J;
                if ($urandom_range(0, 3) != 0)
                    w[25:0] = 26'($urandom_range(0, 511));
            end
            12:
            begin
                w[31:26] = $urandom_range(0, 1) ? OPC_RTYPE : OPC_ALT;
                do
                    code = 6'($urandom());
                while (code inside {FN_ADD, FN_SUB, FN_SLT, FN_SLTU,
                                    FN_AND, FN_OR, FN_SHL16, FN_NOTA});
                w[5:0] = code;
            end
            13:
            begin
                do
                    code = 6'($urandom());
                while (code inside {OPC_RTYPE, OPC_ALT, OPC_SLTU, OPC_ADDI, OPC_LW,
                                    OPC_SW, OPC_LUI, OPC_BEQ, OPC_J});
                w[31:26] = code;
            end
            default:
                w = w;
        endcase
        return w;
    endfunction

    task automatic push_request(logic [1:0] op, logic [15:0] idx, logic [31:0] data);
        req_t r;
        r.operation = op;
        r.load_index = idx;
        r.load_data = data;
        void'(execute_request(PLAN_VIEW, r));
        request_queue.push_back(r);
        if (op != OP_IGNORED)
            planned_items++;
    endtask

    task automatic push_step();
        logic [31:0] w, addr;
        int unsigned at;
        // fill any word the core is about to read before it reads it
        if (!core_halt[PLAN_VIEW] && core_pc[PLAN_VIEW][1:0] == 2'b00
            && (core_pc[PLAN_VIEW] >> 2) < MEM_WORDS)
        begin
            at = core_pc[PLAN_VIEW] >> 2;
            if (!word_written[at])
                push_request(OP_PRELOAD, 16'(at), random_instruction());
            w = core_mem[PLAN_VIEW][at];
            if (w[31:26] == OPC_LW)
            begin
                addr = core_regs[PLAN_VIEW][w[25:21]] + {{16{w[15]}}, w[15:0]};
                at = (addr >> 2) % MEM_WORDS;
                if (!word_written[at])
                    push_request(OP_PRELOAD, 16'(at), $urandom());
            end
        end
        push_request(OP_STEP, 16'($urandom()), $urandom());
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || request_bus.valid || item_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [31:0] entry, int send_pct, int recv_pct, int length,
                             bit hold);
        int unsigned at;
        int          pick;
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= entry;
        @(posedge clk);
        cfg_we <= 1'b0;
        start_addr = entry;
        settings_used++;
        planned_items = 0;
        if (entry[1:0] == 2'b00 && (entry >> 2) < MEM_WORDS)
            for (at = entry >> 2; at < MEM_WORDS && at < (entry >> 2) + 24; at++)
                push_request(OP_PRELOAD, 16'(at), random_instruction());
        push_request(OP_RESTART, 16'($urandom()), $urandom());
        if (hold)
            hold_requests <= hold_requests + 1;
        while (planned_items < length)
        begin
            pick = $urandom_range(0, 99);
            if (core_halt[PLAN_VIEW] && pick < 60)
                push_request(OP_RESTART, 16'($urandom()), $urandom());
            else if (pick < 70)
                push_step();
            else if (pick < 80)
                push_request(OP_PRELOAD, 16'($urandom()), $urandom());
            else if (pick < 88)
                push_request(OP_PRELOAD,
                             16'(((core_pc[PLAN_VIEW] >> 2) + $urandom_range(0, 6)) % MEM_WORDS),
                             random_instruction());
            else if (pick < 92)
                push_request(OP_RESTART, 16'($urandom()), $urandom());
            else if (pick < 94)
                push_request(OP_IGNORED, 16'($urandom()), $urandom());
            else
                push_step();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            request_bus.valid <= 1'b0;
        else
        begin
            if (request_bus.valid && request_bus.ready)
            begin
                item_outcomes.push_back(execute_request(ACCEPT_VIEW, request_bus.data));
                accepted++;
                if (request_bus.data.operation == OP_STEP)
                    steps_accepted++;
            end
            if (!request_bus.valid || request_bus.ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    request_bus.data <= request_queue.pop_front();
                    request_bus.valid <= 1'b1;
                end
                else
                    request_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got = result_bus.data;
                results_checked++;
                if (got.halted)
                    halted_results++;
                if (item_outcomes.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = item_outcomes.pop_front();
                    if (got !== want)
                        errors++;
                    if (got.halted !== want.halted)
                        $error("halted: expected %0d, got %0d", want.halted, got.halted);
                    if (got.pc_after !== want.pc_after)
                        $error("pc_after: expected %h, got %h", want.pc_after, got.pc_after);
                    if (got.fetched_instruction !== want.fetched_instruction)
                        $error("fetched_instruction: expected %h, got %h",
                               want.fetched_instruction, got.fetched_instruction);
                    if (got.alu_result !== want.alu_result)
                        $error("alu_result: expected %h, got %h", want.alu_result, got.alu_result);
                    if (got.zero_flag !== want.zero_flag)
                        $error("zero_flag: expected %0d, got %0d", want.zero_flag, got.zero_flag);
                    if (got.reg_write_done !== want.reg_write_done)
                        $error("reg_write_done: expected %0d, got %0d",
                               want.reg_write_done, got.reg_write_done);
                    if (got.reg_write_index !== want.reg_write_index)
                        $error("reg_write_index: expected %0d, got %0d",
                               want.reg_write_index, got.reg_write_index);
                    if (got.reg_write_value !== want.reg_write_value)
                        $error("reg_write_value: expected %h, got %h",
                               want.reg_write_value, got.reg_write_value);
                    if (got.mem_write_done !== want.mem_write_done)
                        $error("mem_write_done: expected %0d, got %0d",
                               want.mem_write_done, got.mem_write_done);
                end
            end
            // stall result side for a long stretch when asked
            if (hold_seen != hold_requests)
            begin
                hold_seen <= hold_requests;
                hold_left <= HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        request_bus.valid = 1'b0;
        request_bus.data = '0;
        result_bus.ready = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 47;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_request(OP_PRELOAD, 16'd0, {OPC_ADDI, 5'd0, 5'd1, 16'hFFFF});
        push_request(OP_PRELOAD, 16'd1, {OPC_LUI, 5'd0, 5'd2, 16'h8000});
        push_request(OP_PRELOAD, 16'd2, {OPC_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD});
        push_request(OP_PRELOAD, 16'd3, {OPC_ALT, 5'd2, 5'd1, 5'd4, 5'd0, FN_SLT});
        push_request(OP_PRELOAD, 16'd4, {OPC_SLTU, 5'd1, 5'd2, 5'd5, 11'd0});
        push_request(OP_PRELOAD, 16'd5, {OPC_SW, 5'd0, 5'd1, 16'h0100});
        push_request(OP_PRELOAD, 16'd6, {OPC_LW, 5'd0, 5'd6, 16'h0100});
        push_request(OP_PRELOAD, 16'd7, {OPC_BEQ, 5'd5, 5'd0, 16'd1});
        push_request(OP_PRELOAD, 16'd9, {OPC_J, 26'd11});
        push_request(OP_PRELOAD, 16'd11, {OPC_RTYPE, 5'd3, 5'd4, 5'd7, 5'd0, FN_UNUSED});
        repeat (11) push_step();
        push_request(OP_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
        push_request(OP_IGNORED, 16'hFFFF, 32'hFFFF_FFFF);

        run_phase(32'h0000_0400, 36, 47, 300, 1'b1);
        run_phase(32'hFFFF_FFFF, 36, 47, 50, 1'b0);
        run_phase(32'h0003_FFF0, 36, 47, 250, 1'b0);
        run_phase({14'd0, 16'($urandom()), 2'b00}, 47, 36, 350, 1'b1);
        run_phase(32'h0004_0000, 47, 36, 50, 1'b0);
        run_phase(32'hFFFF_FFFC, 0, 0, 50, 1'b0);
        run_phase(32'h0000_0000, 0, 0, 550, 1'b0);
        wait_drained();

        $display("%0d requests accepted, %0d instruction steps, %0d results checked",
                 accepted, steps_accepted, results_checked);
        $display("%0d start_pc settings, %0d results with the core halted",
                 settings_used, halted_results);
        if (errors == 0)
            $display("mips_subset_single_cycle_core: match");
        else
            $display("mips_subset_single_cycle_core: mismatch");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("run exceeded its time limit");
        $display("mips_subset_single_cycle_core: mismatch");
        $finish;
    end

endmodule
